// ===== design/lpd_pkg.sv =====
// shared types, constants and widths of the length-prefixed deframer
package lpd_pkg;

    localparam int BYTE_W          = 8;
    localparam int ID_W            = 16;
    localparam int LEN_W           = 32;
    localparam int LIMIT_W         = 17;
    localparam int MAX_PAYLOAD_DEF = 64 * 1024;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_ID  = 2'd1,
        PH_PAY = 2'd2
    } t_phase;

    typedef enum logic {
        ST_OK  = 1'b0,
        ST_ERR = 1'b1
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   frame_tag;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              last;
        t_status           status;
    } t_result;

endpackage

// ===== design/lpd_if.sv =====
// stream interfaces of the length-prefixed deframer

interface lpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if;
    logic                      valid;
    logic                      ready;
    logic [lpd_pkg::ID_W-1:0]   frame_tag;
    logic [lpd_pkg::BYTE_W-1:0] payload_byte;
    logic                      byte_valid;
    logic                      last;
    logic                      status;

    modport source (output valid, output frame_tag, output payload_byte, output byte_valid,
                    output last, output status, input ready);
    modport sink   (input valid, input frame_tag, input payload_byte, input byte_valid,
                    input last, input status, output ready);
endinterface

interface lpd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lpd_pkg::LIMIT_W-1:0] payload_limit;

    modport source (output valid, output payload_limit, input ready);
    modport sink   (input valid, input payload_limit, output ready);
endinterface

// ===== design/lpd_parser.sv =====
// frame parser: header assembly, length check and per-byte result generation
module lpd_parser #(
    parameter int MAX_PAYLOAD = lpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lpd_pkg::LIMIT_W-1:0] i_cfg_limit,
    input  logic                        i_accept,
    input  logic [lpd_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_res_valid,
    output lpd_pkg::t_result            o_res
);
    import lpd_pkg::*;

    localparam int LEFT_W = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_PAYLOAD);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_hcnt, n_hcnt;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [ID_W-1:0]    r_id, n_id;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [LIMIT_W-1:0] r_limit;

    logic [LIMIT_W-1:0] lim_eff;
    logic [LEN_W-1:0]   lim_plus2;
    logic [ID_W-1:0]    id_next;
    logic               bad_len;

    always_comb begin
        lim_eff   = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;
        lim_plus2 = LEN_W'(lim_eff) + LEN_W'(2);
        id_next   = {r_id[ID_W-BYTE_W-1:0], i_data_byte};
        bad_len   = (r_len < LEN_W'(2)) || (r_len > lim_plus2);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_len   = r_len;
        n_id    = r_id;
        n_left  = r_left;
        if (i_accept) begin
            unique case (r_phase)
                PH_ID: begin
                    n_id   = id_next;
                    n_hcnt = r_hcnt + 2'd1;
                    if (r_hcnt == 2'd1) begin
                        if (bad_len || r_len == LEN_W'(2)) begin
                            n_phase = PH_LEN;
                            n_hcnt  = '0;
                            n_len   = '0;
                            n_id    = '0;
                            n_left  = '0;
                        end else begin
                            n_phase = PH_PAY;
                            n_hcnt  = '0;
                            n_left  = LEFT_W'(r_len - LEN_W'(2));
                        end
                    end
                end
                PH_PAY: begin
                    n_left = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_phase = PH_LEN;
                        n_hcnt  = '0;
                        n_len   = '0;
                        n_id    = '0;
                        n_left  = '0;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                    n_len   = {r_len[LEN_W-BYTE_W-1:0], i_data_byte};
                    n_hcnt  = r_hcnt + 2'd1;
                    if (r_hcnt == 2'd3) begin
                        n_phase = PH_ID;
                        n_id    = '0;
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{frame_tag: r_id, payload_byte: '0, byte_valid: 1'b0,
                        last: 1'b1, status: ST_OK};
        if (i_accept) begin
            unique case (r_phase)
                PH_ID: begin
                    o_res.frame_tag = id_next;
                    if (r_hcnt == 2'd1 && (bad_len || r_len == LEN_W'(2))) begin
                        o_res_valid  = 1'b1;
                        o_res.status = bad_len ? ST_ERR : ST_OK;
                    end
                end
                PH_PAY: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_data_byte;
                    o_res.byte_valid   = 1'b1;
                    o_res.last         = (r_left == LEFT_W'(1));
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_hcnt  <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_left  <= '0;
            r_limit <= LIMIT_MAX;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_len   <= n_len;
            r_id    <= n_id;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
        end
    end

endmodule

// ===== design/lpd_skid.sv =====
// two-entry result stage: output register plus skid register
module lpd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lpd_pkg::t_result i_data,
    output logic             o_up_ready,
    output logic             o_valid,
    output lpd_pkg::t_result o_data,
    input  logic             i_dn_ready
);
    import lpd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_dn_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_valid;
            end
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_up_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

endmodule

// ===== design/length_prefixed_deframer.sv =====
// Length-prefixed deframer top level. Takes one stream byte per clock while ready: a 4-byte
// big-endian length, a 2-byte big-endian packet id, then length minus 2 payload bytes. Each
// payload byte gives one result tagged with the id, the final one marked last; an empty
// payload gives a single byteless last result, and a length below 2 or above 2 plus the
// payload limit gives one error result and a return to header hunting. All parsing is
// combinational from the accepted byte to the result register or, when the output stalls,
// to the skid register. The result register plus a skid register keep the input ready while
// one result waits, so one byte per clock holds as long as the sink takes one result per
// clock. The payload limit register is written through its own channel, which is always
// ready.
module length_prefixed_deframer #(
    parameter int MAX_PAYLOAD = lpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpd_cfg_if.sink   i_cfg,
    lpd_in_if.sink    i_in,
    lpd_out_if.source o_out
);
    import lpd_pkg::*;

    logic    acc;
    logic    res_valid;
    t_result res;
    logic    up_ready;
    t_result out_data;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = up_ready;
    assign acc         = i_in.valid && up_ready;

    lpd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_limit (i_cfg.payload_limit),
        .i_accept    (acc),
        .i_data_byte (i_in.data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpd_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .i_data     (res),
        .o_up_ready (up_ready),
        .o_valid    (o_out.valid),
        .o_data     (out_data),
        .i_dn_ready (o_out.ready)
    );

    assign o_out.frame_tag    = out_data.frame_tag;
    assign o_out.payload_byte = out_data.payload_byte;
    assign o_out.byte_valid   = out_data.byte_valid;
    assign o_out.last         = out_data.last;
    assign o_out.status       = out_data.status;

endmodule

// ===== design/lpd_checker.sv =====
// port-level assertions for the length-prefixed deframer and their bind
module lpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_frame_tag,
    input logic [7:0]  i_payload_byte,
    input logic        i_byte_valid,
    input logic        i_last,
    input logic        i_status
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_frame_tag) && $stable(i_payload_byte)
            && $stable(i_last) && $stable(i_status))
        else $error("stalled result changed");

    // error and empty results close the frame and carry no byte
    a_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_last && i_payload_byte == 8'd0)
        else $error("byteless result not last or nonzero byte");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> !i_byte_valid)
        else $error("error result carries a byte");

    // input only stalls when a result is pending
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_frame_tag    (o_out.frame_tag),
    .i_payload_byte (o_out.payload_byte),
    .i_byte_valid   (o_out.byte_valid),
    .i_last         (o_out.last),
    .i_status       (o_out.status)
);
